### design/tmbs_pkg.sv
// ----------------------------------------------------------------------------
// Tile map background store: shared types and constants
// Command codes, map sizes, coordinate and word widths and the queued command word.
// ----------------------------------------------------------------------------
package tmbs_pkg;

  localparam logic [2:0] CMD_PUT        = 3'd0;
  localparam logic [2:0] CMD_READ       = 3'd1;
  localparam logic [2:0] CMD_FILL       = 3'd2;
  localparam logic [2:0] CMD_CLEAR_LYR  = 3'd3;
  localparam logic [2:0] CMD_CLEAR_PAGE = 3'd4;
  localparam logic [2:0] CMD_COPY       = 3'd5;

  localparam int MAP_SIDE    = 64;
  localparam int LAYER_COUNT = 4;

  localparam int COORD_W = 6;
  localparam int WORD_W  = 16;

  // One classified command as it passes from the front to the back part.
  typedef struct packed {
    logic [2:0]         command;
    logic               page;
    logic               layer;
    logic [COORD_W-1:0] x_first;
    logic [COORD_W-1:0] y_first;
    logic [COORD_W-1:0] x_last;
    logic [COORD_W-1:0] y_last;
    logic [COORD_W-1:0] dest_x;
    logic [COORD_W-1:0] dest_y;
    logic [WORD_W-1:0]  tile_word;
    logic               empty_rect;
  } cmd_t;

endpackage

### design/tmbs_front.sv
// ----------------------------------------------------------------------------
// Tile map background store: front part
// Holds the page register, accepts commands, classifies them and queues them.
// ----------------------------------------------------------------------------
module tmbs_front #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  output logic                 full,
  input  logic [2:0]           command,
  input  logic                 layer,
  input  logic [5:0]           x_first,
  input  logic [5:0]           y_first,
  input  logic [5:0]           x_last,
  input  logic [5:0]           y_last,
  input  logic [5:0]           dest_x,
  input  logic [5:0]           dest_y,
  input  logic [15:0]          tile_word,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic                 cfg_data,
  output logic                 q_valid,
  input  logic                 q_take,
  output tmbs_pkg::cmd_t       q_cmd
);

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

  tmbs_pkg::cmd_t     queue [QUEUE_DEPTH];
  logic [PTR_W-1:0]   wr_ptr;
  logic [PTR_W-1:0]   rd_ptr;
  logic [PTR_W:0]     count;
  logic               active_page;
  tmbs_pkg::cmd_t     incoming;
  logic               do_push;
  logic               do_pop;

  assign cfg_ready = 1'b1;
  assign full      = (count == (PTR_W+1)'(QUEUE_DEPTH));
  assign q_valid   = (count != '0);
  assign q_cmd     = queue[rd_ptr];
  assign do_push   = push && !full;
  assign do_pop    = q_take && q_valid;

  always_comb begin
    incoming.command    = command;
    incoming.page       = active_page;
    incoming.layer      = layer;
    incoming.x_first    = x_first;
    incoming.y_first    = y_first;
    incoming.x_last     = x_last;
    incoming.y_last     = y_last;
    incoming.dest_x     = dest_x;
    incoming.dest_y     = dest_y;
    incoming.tile_word  = tile_word;
    incoming.empty_rect = (x_first > x_last) || (y_first > y_last);
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      queue[wr_ptr] <= incoming;
    end
    if (rst) begin
      wr_ptr      <= '0;
      rd_ptr      <= '0;
      count       <= '0;
      active_page <= 1'b0;
    end else begin
      if (cfg_valid) begin
        active_page <= cfg_data;
      end
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(QUEUE_DEPTH-1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(QUEUE_DEPTH-1)) ? '0 : rd_ptr + 1'b1;
      end
      count <= count + (PTR_W+1)'(do_push) - (PTR_W+1)'(do_pop);
    end
  end

endmodule

### design/tmbs_back.sv
// ----------------------------------------------------------------------------
// Tile map background store: back part
// Owns the tile memory and the snapshot memory and walks the cells of each
// command, sending one result word per command to a one-word output register.
// ----------------------------------------------------------------------------
module tmbs_back (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 q_valid,
  output logic                 q_take,
  input  tmbs_pkg::cmd_t       q_cmd,
  output logic                 empty,
  input  logic                 pop,
  output logic [15:0]          read_word
);

  localparam int CW     = $clog2(tmbs_pkg::MAP_SIDE);
  localparam int LW     = $clog2(tmbs_pkg::LAYER_COUNT);
  localparam int CELLS  = tmbs_pkg::MAP_SIDE * tmbs_pkg::MAP_SIDE;
  localparam int DEPTH  = tmbs_pkg::LAYER_COUNT * CELLS;
  localparam int AW     = LW + 2 * CW;

  typedef enum logic [7:0] {
    ST_CLEARING = 8'b0000_0001,
    ST_IDLE     = 8'b0000_0010,
    ST_READ     = 8'b0000_0100,
    ST_FILL     = 8'b0000_1000,
    ST_CLR      = 8'b0001_0000,
    ST_SNAP     = 8'b0010_0000,
    ST_WBACK    = 8'b0100_0000,
    ST_DONE     = 8'b1000_0000
  } state_t;

  logic [15:0]   tile_mem [DEPTH];
  logic [15:0]   snap_mem [CELLS];

  state_t        state;
  tmbs_pkg::cmd_t cur;
  logic [AW:0]   sweep;
  logic [CW-1:0] cx, cy;
  logic          clr_second;
  logic          clr_both;
  logic [LW-1:0] map_sel;

  // Read pipeline for the snapshot and write-back passes.
  logic          rd_pend;
  logic [CW-1:0] rd_dx, rd_dy;
  logic [15:0]   tile_q, snap_q;

  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [15:0]   mem_wdata;
  logic [AW-1:0] mem_raddr;

  logic [15:0]   res_word;
  logic          res_hold;
  logic          res_push;
  logic [15:0]   res_data;
  logic          read_pend;

  function automatic logic [LW-1:0] map_of(input logic page, input logic lyr);
    logic [2:0] m;
    m = {1'b0, page, 1'b0} + {2'b00, lyr};
    return LW'(m % 3'(tmbs_pkg::LAYER_COUNT));
  endfunction

  function automatic logic [AW-1:0] addr_of(input logic [LW-1:0] m,
                                            input logic [CW-1:0] x,
                                            input logic [CW-1:0] y);
    return {m, y, x};
  endfunction

  logic [CW-1:0] x1w, y1w, x2w, y2w;
  logic [CW-1:0] dxw, dyw;
  assign x1w = CW'(cur.x_first);
  assign y1w = CW'(cur.y_first);
  assign x2w = CW'(cur.x_last);
  assign y2w = CW'(cur.y_last);
  assign dxw = CW'(cur.dest_x) + (cx - x1w);
  assign dyw = CW'(cur.dest_y) + (cy - y1w);

  // Rectangle walk order: x outer, y inner, on 6-bit values.
  logic [5:0] wx, wy;
  logic       walk_end;
  assign wx = 6'(cx);
  assign wy = 6'(cy);
  assign walk_end = (wx == cur.x_last) && (wy == cur.y_last);

  assign q_take = (state == ST_IDLE) && q_valid;
  assign empty  = !res_hold;
  assign read_word = res_word;

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = '0;
    mem_wdata = '0;
    mem_raddr = addr_of(map_sel, cx, cy);
    unique case (state)
      ST_CLEARING: begin
        mem_we    = 1'b1;
        mem_waddr = sweep[AW-1:0];
      end
      ST_IDLE: begin
        mem_raddr = addr_of(map_of(q_cmd.page, q_cmd.layer),
                            CW'(q_cmd.x_first), CW'(q_cmd.y_first));
        if (q_valid && q_cmd.command == tmbs_pkg::CMD_PUT) begin
          mem_we    = 1'b1;
          mem_waddr = mem_raddr;
          mem_wdata = q_cmd.tile_word;
        end
      end
      ST_FILL: begin
        mem_we    = 1'b1;
        mem_waddr = addr_of(map_sel, cx, cy);
        mem_wdata = cur.tile_word;
      end
      ST_CLR: begin
        mem_we    = 1'b1;
        mem_waddr = addr_of(map_sel, cx, cy);
      end
      ST_WBACK: begin
        mem_we    = rd_pend;
        mem_waddr = addr_of(map_sel, rd_dx, rd_dy);
        mem_wdata = snap_q;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      tile_mem[mem_waddr] <= mem_wdata;
    end
    tile_q <= tile_mem[mem_raddr];
    snap_q <= snap_mem[{dyw, dxw}];
    if (state == ST_SNAP && rd_pend) begin
      snap_mem[{rd_dy, rd_dx}] <= tile_q;
    end
  end

  always_comb begin
    res_push = 1'b0;
    res_data = '0;
    if (read_pend) begin
      res_push = 1'b1;
      res_data = tile_q;
    end else if (state == ST_DONE && (!res_hold || pop)) begin
      res_push = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (res_push) begin
      res_word <= res_data;
    end
    if (rst) begin
      state      <= ST_CLEARING;
      sweep      <= '0;
      res_hold   <= 1'b0;
      read_pend  <= 1'b0;
      rd_pend    <= 1'b0;
      clr_second <= 1'b0;
      clr_both   <= 1'b0;
    end else begin
      read_pend <= 1'b0;
      if (res_push) begin
        res_hold <= 1'b1;
      end else if (pop && res_hold) begin
        res_hold <= 1'b0;
      end
      unique case (state)
        ST_CLEARING: begin
          sweep <= sweep + 1'b1;
          if (sweep == (AW+1)'(DEPTH-1)) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          // A put is written here at once; every result then waits in
          // ST_READ or ST_DONE until the output word is free.
          if (q_valid) begin
            cur     <= q_cmd;
            map_sel <= map_of(q_cmd.page, q_cmd.layer);
            cx      <= CW'(q_cmd.x_first);
            cy      <= CW'(q_cmd.y_first);
            rd_pend <= 1'b0;
            unique case (q_cmd.command)
              tmbs_pkg::CMD_READ: begin
                state <= ST_READ;
              end
              tmbs_pkg::CMD_FILL: begin
                state <= q_cmd.empty_rect ? ST_DONE : ST_FILL;
              end
              tmbs_pkg::CMD_CLEAR_LYR: begin
                cx       <= '0;
                cy       <= '0;
                clr_both <= 1'b0;
                state    <= ST_CLR;
              end
              tmbs_pkg::CMD_CLEAR_PAGE: begin
                cx         <= '0;
                cy         <= '0;
                map_sel    <= map_of(q_cmd.page, 1'b0);
                clr_both   <= 1'b1;
                clr_second <= 1'b0;
                state      <= ST_CLR;
              end
              tmbs_pkg::CMD_COPY: begin
                state <= q_cmd.empty_rect ? ST_DONE : ST_SNAP;
              end
              default: begin
                state <= ST_DONE;
              end
            endcase
          end
        end
        ST_READ: begin
          if (!res_hold || pop) begin
            read_pend <= 1'b1;
            state     <= ST_IDLE;
          end
        end
        ST_FILL: begin
          if (walk_end) begin
            state <= ST_DONE;
          end else if (wy == cur.y_last) begin
            cy <= y1w;
            cx <= cx + 1'b1;
          end else begin
            cy <= cy + 1'b1;
          end
        end
        ST_CLR: begin
          cx <= cx + 1'b1;
          if (cx == CW'(tmbs_pkg::MAP_SIDE-1)) begin
            cy <= cy + 1'b1;
            if (cy == CW'(tmbs_pkg::MAP_SIDE-1)) begin
              if (clr_both && !clr_second) begin
                clr_second <= 1'b1;
                map_sel    <= map_of(cur.page, 1'b1);
              end else begin
                state <= ST_DONE;
              end
            end
          end
        end
        ST_SNAP, ST_WBACK: begin
          rd_pend <= 1'b1;
          rd_dx   <= dxw;
          rd_dy   <= dyw;
          if (rd_pend && rd_dx == CW'(CW'(cur.dest_x) + (x2w - x1w)) &&
              rd_dy == CW'(CW'(cur.dest_y) + (y2w - y1w)) &&
              (wx == cur.x_first) && (wy == cur.y_first)) begin
            rd_pend <= 1'b0;
            cx      <= x1w;
            cy      <= y1w;
            state   <= (state == ST_SNAP) ? ST_WBACK : ST_DONE;
          end else if (walk_end) begin
            cx <= x1w;
            cy <= y1w;
          end else if (wy == cur.y_last) begin
            cy <= y1w;
            cx <= cx + 1'b1;
          end else begin
            cy <= cy + 1'b1;
          end
        end
        ST_DONE: begin
          if (!res_hold || pop) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

### design/tile_map_background_store_core.sv
// ----------------------------------------------------------------------------
// Tile map background store
// Four maps of tile words addressed by page and layer, with put, read,
// fill, clear and copy commands.
// ----------------------------------------------------------------------------
// Usage: commands enter on the push/full queue interface; each command
// yields exactly one result word on the empty/pop interface, holding the
// tile read for a read command and zero for every other command.
// The page register is written on the cfg_valid/cfg_ready channel; the user
// must write it only while the block is idle, as the block does not enforce
// this. It is sampled as each command is accepted. A put writes the tile
// memory as it is taken from the queue. Fill walks each cell of its
// rectangle, clear layer all MAP_SIDE*MAP_SIDE cells of one map and clear
// page those of both maps of the page. Copy makes two passes: a snapshot
// pass into the snapshot memory and a write-back pass into the tile memory.
// After reset all LAYER_COUNT*MAP_SIDE*MAP_SIDE tile words are cleared one
// word per cycle, and no command starts until the clearing is done.
// When pop is held low the back part stops before it would deliver the
// next result word, and full rises once the queue is taken up.
// ----------------------------------------------------------------------------
module tile_map_background_store_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic [2:0]  command,
  input  logic        layer,
  input  logic [5:0]  x_first,
  input  logic [5:0]  y_first,
  input  logic [5:0]  x_last,
  input  logic [5:0]  y_last,
  input  logic [5:0]  dest_x,
  input  logic [5:0]  dest_y,
  input  logic [15:0] tile_word,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_data,
  output logic        empty,
  input  logic        pop,
  output logic [15:0] read_word,
  output logic [9:0]  read_chr,
  output logic [3:0]  read_palette,
  output logic        read_hflip,
  output logic        read_vflip
);

  logic           q_valid;
  logic           q_take;
  tmbs_pkg::cmd_t q_cmd;

  tmbs_front u_front (
    .clk, .rst, .push, .full, .command, .layer, .x_first, .y_first,
    .x_last, .y_last, .dest_x, .dest_y, .tile_word,
    .cfg_valid, .cfg_ready, .cfg_data,
    .q_valid, .q_take, .q_cmd
  );

  tmbs_back u_back (
    .clk, .rst, .q_valid, .q_take, .q_cmd, .empty, .pop, .read_word
  );

  assign read_chr     = read_word[9:0];
  assign read_hflip   = read_word[10];
  assign read_vflip   = read_word[11];
  assign read_palette = read_word[15:12];

endmodule
